// File: rtl/core/assert_macros.svh
// Assertion macros shared by the page frame allocator RTL.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PFA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfa assertion failed");
`define PFA_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pfa forbidden condition seen");
`else
`define PFA_ASSERT(name, prop)
`define PFA_ASSERT_NEVER(name, expr)
`endif

`endif

// File: rtl/core/pfa_pkg.sv
// Package for the page frame allocator: sizes, codes and transfer structs.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int unsigned AddrW     = 56;
  localparam int unsigned PageShift = 12;
  localparam int unsigned NumPages  = 4096;
  localparam int unsigned Reserved  = 1;
  localparam int unsigned ResvClamp = (Reserved > NumPages) ? NumPages : Reserved;
  localparam int unsigned InitTop   = NumPages - ResvClamp;
  localparam int unsigned PageIdxW  = $clog2(NumPages);
  localparam int unsigned TopW      = $clog2(NumPages + 1);
  localparam int unsigned FrameW    = AddrW - PageShift;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [AddrW-1:0] RegionBaseRst = AddrW'(64'h8000_0000);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_BAD_ADDRESS = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_BAD   = 2'd2
  } op_kind_e;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] address;
  } pfa_req_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] page_address;
  } pfa_rsp_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    op_kind_e            kind;
    logic [PageIdxW-1:0] idx;
  } pfa_op_t;

endpackage

// File: rtl/core/pfa_op_fifo.sv
// Short queue of classified requests between the front and the back.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_op_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfa_pkg::pfa_op_t  op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pfa_pkg::pfa_op_t  op_o
);
  import pfa_pkg::*;

  pfa_op_t             entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: rtl/core/pfa_front.sv
// Front of the allocator: request intake, region base register and address checks.
// Depends on pfa_pkg; feeds pfa_op_fifo.
`timescale 1ns / 1ps

module pfa_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  pfa_pkg::pfa_req_t         req_i,
  output logic                      full_o,
  input  logic                      cfg_we_i,
  input  logic [pfa_pkg::AddrW-1:0] cfg_wdata_i,
  input  logic                      fifo_full_i,
  input  logic                      init_busy_i,
  output logic                      op_push_o,
  output pfa_pkg::pfa_op_t          op_o,
  output logic [pfa_pkg::AddrW-1:0] region_base_o
);
  import pfa_pkg::*;

  logic [AddrW-1:0]  region_base_q;
  logic [AddrW:0]    diff;
  logic [FrameW-1:0] frame;
  logic              below_base, out_of_range, misaligned;

  // Hold off requests while the memories are being set up
  assign full_o    = fifo_full_i | init_busy_i;
  assign op_push_o = push_i && !full_o;

  assign diff         = {1'b0, req_i.address} - {1'b0, region_base_q};
  assign below_base   = diff[AddrW];
  assign frame        = diff[AddrW-1:PageShift];
  assign out_of_range = (frame >= FrameW'(NumPages));
  assign misaligned   = |req_i.address[PageShift-1:0];

  always_comb begin
    op_o.idx = frame[PageIdxW-1:0];
    if (req_i.command == CMD_ALLOC) begin
      op_o.kind = OP_ALLOC;
    end else if (misaligned || below_base || out_of_range) begin
      op_o.kind = OP_BAD;
    end else begin
      op_o.kind = OP_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= RegionBaseRst;
    end else if (cfg_we_i) begin
      region_base_q <= cfg_wdata_i;
    end
  end

  assign region_base_o = region_base_q;

endmodule

// File: rtl/core/pfa_back.sv
// Back of the allocator: free stack and in-use map memories, sequencer and result register.
// Depends on pfa_pkg and assert_macros.svh; takes work from pfa_op_fifo.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfa_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      op_valid_i,
  input  pfa_pkg::pfa_op_t          op_i,
  output logic                      op_pop_o,
  input  logic [pfa_pkg::AddrW-1:0] region_base_i,
  output logic                      init_busy_o,
  output logic                      rsp_valid_o,
  input  logic                      pop_i,
  output pfa_pkg::pfa_rsp_t         rsp_o
);
  import pfa_pkg::*;

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [TopW-1:0]     top_q, top_d;
  logic [PageIdxW-1:0] init_cnt_q, init_cnt_d;
  logic [PageIdxW-1:0] idx_q, idx_d;
  pfa_rsp_t            rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic                rsp_load, slot_free;

  logic [PageIdxW-1:0] stack_mem [NumPages];
  logic                map_mem   [NumPages];

  logic                stk_we, stk_re, map_we, map_wdata, map_re;
  logic [PageIdxW-1:0] stk_waddr, stk_wdata, stk_raddr, map_waddr, map_raddr;
  logic [PageIdxW-1:0] stk_rdata_q;
  logic                map_rdata_q;

  assign slot_free   = !rsp_valid_q || pop_i;
  assign init_busy_o = (state_q == S_INIT);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    init_cnt_d = init_cnt_q;
    idx_d      = idx_q;
    rsp_d      = rsp_q;
    rsp_load   = 1'b0;
    op_pop_o   = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = PageIdxW'(top_q);
    stk_wdata  = idx_q;
    stk_re     = 1'b0;
    stk_raddr  = PageIdxW'(top_q - TopW'(1));
    map_we     = 1'b0;
    map_waddr  = idx_q;
    map_wdata  = 1'b0;
    map_re     = 1'b0;
    map_raddr  = op_i.idx;

    case (state_q)
      S_INIT: begin
        // Sweep both memories: stack gets its ascending page list, map its reserved marks
        stk_we     = 1'b1;
        stk_waddr  = init_cnt_q;
        stk_wdata  = PageIdxW'({1'b0, init_cnt_q} + TopW'(ResvClamp));
        map_we     = 1'b1;
        map_waddr  = init_cnt_q;
        map_wdata  = ({1'b0, init_cnt_q} < TopW'(ResvClamp));
        init_cnt_d = init_cnt_q + PageIdxW'(1);
        if (init_cnt_q == PageIdxW'(NumPages - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid_i && slot_free) begin
          op_pop_o = 1'b1;
          idx_d    = op_i.idx;
          case (op_i.kind)
            OP_ALLOC: begin
              if (top_q == '0) begin
                rsp_load = 1'b1;
                rsp_d    = '{status: ST_EMPTY, page_address: '0};
              end else begin
                stk_re  = 1'b1;
                state_d = S_ALLOC;
              end
            end
            OP_FREE: begin
              map_re  = 1'b1;
              state_d = S_FREE;
            end
            default: begin
              rsp_load = 1'b1;
              rsp_d    = '{status: ST_BAD_ADDRESS, page_address: '0};
            end
          endcase
        end
      end
      S_ALLOC: begin
        map_we    = 1'b1;
        map_waddr = stk_rdata_q;
        map_wdata = 1'b1;
        top_d     = top_q - TopW'(1);
        rsp_load  = 1'b1;
        rsp_d     = '{status: ST_OK,
                      page_address: region_base_i +
                        {{(FrameW - PageIdxW){1'b0}}, stk_rdata_q, {PageShift{1'b0}}}};
        state_d   = S_IDLE;
      end
      S_FREE: begin
        rsp_load = 1'b1;
        if (!map_rdata_q || (top_q >= TopW'(NumPages))) begin
          rsp_d = '{status: ST_DOUBLE_FREE, page_address: '0};
        end else begin
          map_we = 1'b1;
          stk_we = 1'b1;
          top_d  = top_q + TopW'(1);
          rsp_d  = '{status: ST_OK, page_address: '0};
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_valid_d = rsp_load | (rsp_valid_q & ~pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      top_q       <= TopW'(InitTop);
      init_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      init_cnt_q  <= init_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  `PFA_ASSERT(a_no_rsp_overwrite, (rsp_load && rsp_valid_q) |-> pop_i)
  `PFA_ASSERT(a_alloc_pops_stack, (state_q == S_ALLOC) |=> (top_q == $past(top_q) - TopW'(1)))
  `PFA_ASSERT_NEVER(a_top_overflow, top_q > TopW'(NumPages))
  `PFA_ASSERT_NEVER(a_work_during_init, (state_q == S_INIT) && (op_pop_o || rsp_load))

endmodule

// File: rtl/core/page_frame_allocator_unit.sv
// Page frame allocator: hands out and takes back 4 KiB pages of one physical region,
// using a LIFO free stack and an in-use map held in on-chip memories. After reset the
// block sweeps both memories, one page per cycle over all NumPages (4096) pages, and
// holds full high until that is done. A free whose address fails the checks, or an
// allocate on an empty stack, is answered from the back end's idle state. An allocate
// from a non-empty stack, or a free of an aligned in-region page (whether in use or
// not), first goes through the registered read of the stack or map memory before the
// update. A two-entry request queue sits between the address checks and the back end,
// and the back end takes a request only while its result register is empty or popped.
// Write region_base only while no request is outstanding.
`timescale 1ns / 1ps

module page_frame_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  pfa_pkg::pfa_req_t         req_i,
  output logic                      empty,
  input  logic                      pop,
  output pfa_pkg::pfa_rsp_t         rsp_o,
  input  logic                      cfg_we_i,
  input  logic [pfa_pkg::AddrW-1:0] cfg_wdata_i
);
  import pfa_pkg::*;

  logic             fifo_full, fifo_valid, op_push, op_pop, init_busy, rsp_valid;
  pfa_op_t          front_op, fifo_op;
  logic [AddrW-1:0] region_base;

  pfa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .req_i         (req_i),
    .full_o        (full),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_full_i   (fifo_full),
    .init_busy_i   (init_busy),
    .op_push_o     (op_push),
    .op_o          (front_op),
    .region_base_o (region_base)
  );

  pfa_op_fifo u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (front_op),
    .full_o  (fifo_full),
    .pop_i   (op_pop),
    .valid_o (fifo_valid),
    .op_o    (fifo_op)
  );

  pfa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (fifo_valid),
    .op_i          (fifo_op),
    .op_pop_o      (op_pop),
    .region_base_i (region_base),
    .init_busy_o   (init_busy),
    .rsp_valid_o   (rsp_valid),
    .pop_i         (pop),
    .rsp_o         (rsp_o)
  );

  assign empty = !rsp_valid;

endmodule
